### hdl/gmp_pkg.sv
package gmp_pkg;

    // Fixed field widths
    localparam int TOTAL_W   = 24;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Default sizes
    localparam int DEF_MAX_ROWS  = 256;
    localparam int DEF_MAX_COLS  = 256;
    localparam int DEF_GOLD_BITS = 16;

    // Size value taken after reset
    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Position flags of one cell
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
    } gmp_ctl_t;

    // Map a size register to the index of the last row or column in use
    function automatic logic [31:0] last_index(input logic [CFG_W-1:0] v,
                                               input int unsigned limit);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return 32'd0;
        end
        else if (v32 > limit) begin
            return limit - 32'd1;
        end
        else begin
            return v32 - 32'd1;
        end
    endfunction

endpackage

### hdl/gmp_column_ram.sv
module gmp_column_ram
    import gmp_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_ROWS,
    parameter int ADDR_W = 8
)
(
    input  logic               clk,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr_a,
    input  logic [ADDR_W-1:0]  rd_addr_b,
    output logic [TOTAL_W-1:0] rd_data_a,
    output logic [TOTAL_W-1:0] rd_data_b,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TOTAL_W-1:0] wr_data
);

    logic [TOTAL_W-1:0] mem [DEPTH];

    // Write one total per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read both neighbors; hold data while no cell is taken
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### hdl/gmp_cell_unit.sv
module gmp_cell_unit
    import gmp_pkg::*;
#(
    parameter int ROW_W     = 8,
    parameter int GOLD_BITS = DEF_GOLD_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [GOLD_BITS-1:0] gold_in,
    input  logic [ROW_W-1:0]     row_in,
    input  logic [ROW_W-1:0]     row_below_in,
    input  gmp_ctl_t             ctl_in,
    input  logic                 restart,
    input  logic [TOTAL_W-1:0]   rd_here,
    input  logic [TOTAL_W-1:0]   rd_below,
    output logic                 busy,
    output logic                 wr_en,
    output logic [ROW_W-1:0]     wr_addr,
    output logic [TOTAL_W-1:0]   wr_data,
    output logic                 out_valid,
    output logic [TOTAL_W-1:0]   out_total,
    input  logic                 out_stall
);

    localparam int SUM_W = ((GOLD_BITS > TOTAL_W) ? GOLD_BITS : TOTAL_W) + 1;

    logic                 s1_valid_reg, s1_valid_next;
    logic [GOLD_BITS-1:0] s1_gold_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    gmp_ctl_t             s1_ctl_reg;
    logic                 here_hit_reg, below_hit_reg;
    logic [TOTAL_W-1:0]   fwd_data_reg;
    logic [TOTAL_W-1:0]   saved_above_reg, saved_above_next;
    logic [TOTAL_W-1:0]   best_reg, best_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic                 s1_adv;
    logic                 emit;
    logic [TOTAL_W-1:0]   old_here, old_below, pick;
    logic [SUM_W-1:0]     sum;
    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W-1:0]   col_best;

    // Pick neighbor totals, bypassing the write that raced the read
    assign old_here  = here_hit_reg  ? fwd_data_reg : rd_here;
    assign old_below = below_hit_reg ? fwd_data_reg : rd_below;

    // Largest neighbor that lies inside the grid
    always_comb
    begin
        pick = old_here;
        if (!s1_ctl_reg.first_row && saved_above_reg > pick) begin
            pick = saved_above_reg;
        end
        if (!s1_ctl_reg.last_row && old_below > pick) begin
            pick = old_below;
        end
    end

    // Add gold and saturate
    always_comb
    begin
        if (s1_ctl_reg.first_col) begin
            sum = SUM_W'(s1_gold_reg);
        end
        else begin
            sum = SUM_W'(s1_gold_reg) + SUM_W'(pick);
        end
        if (sum > SUM_W'(TOTAL_MAX)) begin
            total = TOTAL_MAX;
        end
        else begin
            total = sum[TOTAL_W-1:0];
        end
    end

    // Running maximum over the last column
    assign col_best = (s1_ctl_reg.first_row || total > best_reg) ? total : best_reg;

    assign emit   = s1_ctl_reg.last_col && s1_ctl_reg.last_row;
    assign s1_adv = s1_valid_reg && (!emit || !out_valid_reg || !out_stall);
    assign busy   = s1_valid_reg && !s1_adv;

    assign wr_en   = s1_adv;
    assign wr_addr = s1_row_reg;
    assign wr_data = total;

    // Next control state
    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        saved_above_next = saved_above_reg;
        best_next        = best_reg;
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        if (s1_adv) begin
            s1_valid_next    = 1'b0;
            saved_above_next = s1_ctl_reg.last_row ? '0 : old_here;
            if (s1_ctl_reg.last_col) begin
                best_next = col_best;
            end
            if (emit) begin
                best_next      = '0;
                out_valid_next = 1'b1;
            end
        end
        if (take) begin
            s1_valid_next = 1'b1;
        end
        if (restart) begin
            saved_above_next = '0;
            best_next        = '0;
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            saved_above_reg <= '0;
            best_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            s1_valid_reg    <= s1_valid_next;
            saved_above_reg <= saved_above_next;
            best_reg        <= best_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Load the cell word and note forwarding hits
    always_ff @(posedge clk)
    begin
        if (take) begin
            s1_gold_reg   <= gold_in;
            s1_row_reg    <= row_in;
            s1_ctl_reg    <= ctl_in;
            here_hit_reg  <= wr_en && (wr_addr == row_in);
            below_hit_reg <= wr_en && (wr_addr == row_below_in);
            fwd_data_reg  <= wr_data;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (s1_adv && emit) begin
            out_total_reg <= col_best;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;

endmodule

### hdl/grid_max_path_dp_core.sv
// The result word is registered from the cell stage that holds the last cell of a grid.
// Throughput: one cell per cycle; input stalls only while a result waits at the output.
// The column memory has one write and two read ports, each cell reads two totals.
// Reset: position, running maximum and output clear; both sizes return to 256.
// The column memory is not cleared; every entry is written before its value is used.
module grid_max_path_dp_core
    import gmp_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int GOLD_BITS = DEF_GOLD_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [GOLD_BITS-1:0] gold,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TOTAL_W-1:0]   best_total,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   last_row_reg, last_row_next;
    logic [COL_W-1:0]   last_col_reg, last_col_next;

    logic               take;
    logic               cfg_write;
    logic               restart;
    logic [ROW_W-1:0]   row_below;
    gmp_ctl_t           ctl;
    logic [TOTAL_W-1:0] rd_here, rd_below;
    logic               wr_en;
    logic [ROW_W-1:0]   wr_addr;
    logic [TOTAL_W-1:0] wr_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign take      = in_valid && !in_stall;
    assign row_below = row_reg + 1'b1;

    // Position flags of the cell at the input
    assign ctl.first_row = (row_reg == '0);
    assign ctl.last_row  = (row_reg == last_row_reg);
    assign ctl.first_col = (col_reg == '0);
    assign ctl.last_col  = (col_reg == last_col_reg);

    // Size registers and grid restart
    always_comb
    begin
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        restart       = 1'b0;
        if (cfg_write) begin
            case (cfg_index)
                CFG_NUM_ROWS:
                begin
                    last_row_next = ROW_W'(last_index(cfg_data, MAX_ROWS));
                    restart       = 1'b1;
                end
                CFG_NUM_COLS:
                begin
                    last_col_next = COL_W'(last_index(cfg_data, MAX_COLS));
                    restart       = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Step the position row by row, column by column
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (take) begin
            if (ctl.last_row) begin
                row_next = '0;
                col_next = ctl.last_col ? '0 : col_reg + 1'b1;
            end
            else begin
                row_next = row_reg + 1'b1;
            end
        end
        if (restart) begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_reg      <= '0;
            col_reg      <= '0;
            last_row_reg <= ROW_W'(last_index(SIZE_RESET, MAX_ROWS));
            last_col_reg <= COL_W'(last_index(SIZE_RESET, MAX_COLS));
        end
        else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
        end
    end

    gmp_column_ram #(
        .DEPTH  (MAX_ROWS),
        .ADDR_W (ROW_W)
    ) u_ram (
        .clk       (clk),
        .rd_en     (take),
        .rd_addr_a (row_reg),
        .rd_addr_b (row_below),
        .rd_data_a (rd_here),
        .rd_data_b (rd_below),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    gmp_cell_unit #(
        .ROW_W     (ROW_W),
        .GOLD_BITS (GOLD_BITS)
    ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .gold_in      (gold),
        .row_in       (row_reg),
        .row_below_in (row_below),
        .ctl_in       (ctl),
        .restart      (restart),
        .rd_here      (rd_here),
        .rd_below     (rd_below),
        .busy         (in_stall),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .out_valid    (out_valid),
        .out_total    (best_total),
        .out_stall    (out_stall)
    );

endmodule

### hdl/gmp_checker.sv
module gmp_checker
    import gmp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [TOTAL_W-1:0] best_total
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_total))
        else $error("result word changed while stalled");

    // Drop a result only once it was taken
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without being taken");

    // Stall input only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // Come out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("block not empty after reset");

endmodule

bind grid_max_path_dp_core gmp_checker u_gmp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_total (best_total)
);

### dv/tb_grid_max_path_dp_core.sv
`timescale 1ns / 1ps

module tb_grid_max_path_dp_core
    import gmp_pkg::*;
();

    localparam int MAX_ROWS    = DEF_MAX_ROWS;
    localparam int MAX_COLS    = DEF_MAX_COLS;
    localparam int GOLD_BITS   = DEF_GOLD_BITS;
    localparam int RAND_CELLS  = 1150;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 4;

    // Register indexes beyond the defined pair
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        logic [GOLD_BITS-1:0]   g;
        bit                     typed;
        logic [TOTAL_W-1:0]     total;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [GOLD_BITS-1:0] gold;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [TOTAL_W-1:0]   best_total;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Predicted grid state
    logic [CFG_W-1:0]     cfg_rows;
    logic [CFG_W-1:0]     cfg_cols;
    logic [TOTAL_W-1:0]   col_tot [MAX_ROWS];
    logic [TOTAL_W-1:0]   above;
    logic [TOTAL_W-1:0]   last_max;
    int unsigned          row_pos;
    int unsigned          col_pos;

    logic [TOTAL_W-1:0]   totals_due [$];
    stim_row_t            dir_rows [$];

    int                   src_gap_pct;
    int                   sink_hold_pct;
    int                   mismatch_count = 0;
    int                   quiet_cycles = 0;
    int unsigned          rand_cells;

    grid_max_path_dp_core #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .GOLD_BITS (GOLD_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .gold       (gold),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_total (best_total),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a size register to the range the block uses
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned limit);
        if (v == '0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    // Advance the path totals by one cell; returns 1 when the grid completes
    function automatic bit grid_step(input logic [GOLD_BITS-1:0] g,
                                     output logic [TOTAL_W-1:0] best);
        int unsigned        rows;
        int unsigned        cols;
        int unsigned        r;
        int unsigned        c;
        int unsigned        pick;
        int unsigned        sum;
        logic [TOTAL_W-1:0] here;
        logic [TOTAL_W-1:0] total;
        bit                 done;
        rows = eff_size(cfg_rows, MAX_ROWS);
        cols = eff_size(cfg_cols, MAX_COLS);
        r    = row_pos;
        c    = col_pos;
        done = 1'b0;
        best = '0;
        if (r >= rows)
        begin
            r = 0;
        end
        if (c >= cols)
        begin
            c = 0;
        end
        here = col_tot[r];
        if (c == 0)
        begin
            sum = g;
        end
        else
        begin
            // best of left, upper-left and lower-left neighbors inside the grid
            pick = here;
            if (r > 0 && above > pick)
            begin
                pick = above;
            end
            if (r + 1 < rows && col_tot[r + 1] > pick)
            begin
                pick = col_tot[r + 1];
            end
            sum = g + pick;
        end
        total = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
        above = here;
        col_tot[r] = total;
        if (c + 1 == cols && (r == 0 || total > last_max))
        begin
            last_max = total;
        end
        r++;
        if (r == rows)
        begin
            r     = 0;
            above = '0;
            if (c + 1 == cols)
            begin
                best     = last_max;
                done     = 1'b1;
                c        = 0;
                last_max = '0;
            end
            else
            begin
                c++;
            end
        end
        row_pos = r;
        col_pos = c;
        return done;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        stim_row_t row;
        row       = '{kind: ROW_CFG, default: '0};
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        return row;
    endfunction

    function automatic stim_row_t cell_row(input logic [GOLD_BITS-1:0] g, input bit typed,
                                           input logic [TOTAL_W-1:0] total);
        stim_row_t row;
        row       = '{kind: ROW_CELL, default: '0};
        row.kind  = ROW_CELL;
        row.g     = g;
        row.typed = typed;
        row.total = total;
        return row;
    endfunction

    // Mostly small sizes, with zero, mid and oversize values now and then
    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            return '0;
        end
        if (sel < 60)
        begin
            return CFG_W'($urandom_range(1, 6));
        end
        if (sel < 85)
        begin
            return CFG_W'($urandom_range(7, 16));
        end
        if (sel < 97)
        begin
            return CFG_W'($urandom_range(17, 40));
        end
        return CFG_W'($urandom_range(41, 511));
    endfunction

    // Present one cell, hold it until taken, then predict
    task automatic feed_cell(input logic [GOLD_BITS-1:0] g, input bit typed,
                             input logic [TOTAL_W-1:0] typed_total);
        logic [TOTAL_W-1:0] total;
        while ($urandom_range(99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            gold     <= GOLD_BITS'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        gold     <= g;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (grid_step(g, total))
        begin
            totals_due.push_back(typed ? typed_total : total);
        end
    endtask

    // Feed cells with random gold, biased toward the extremes
    task automatic feed_cells(input int unsigned n);
        int unsigned          sel;
        logic [GOLD_BITS-1:0] g;
        repeat (n)
        begin
            sel = $urandom_range(99);
            if (sel < 10)
            begin
                g = '0;
            end
            else if (sel < 20)
            begin
                g = '1;
            end
            else
            begin
                g = GOLD_BITS'($urandom);
            end
            feed_cell(g, 1'b0, '0);
            rand_cells++;
        end
    endtask

    // Hold the input low until every result is out and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (totals_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register and mirror it in the prediction
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NUM_ROWS: cfg_rows = data;
            CFG_NUM_COLS: cfg_cols = data;
            default: ;
        endcase
        // a write to a defined register restarts the grid
        if (idx == CFG_NUM_ROWS || idx == CFG_NUM_COLS)
        begin
            above    = '0;
            last_max = '0;
            row_pos  = 0;
            col_pos  = 0;
        end
    endtask

    // Check result words and drive random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (totals_due.size() == 0)
            begin
                $error("best_total: expected none, actual %0d", best_total);
                mismatch_count++;
            end
            else
            begin
                if (best_total !== totals_due[0])
                begin
                    $error("best_total: expected %0d, actual %0d", totals_due[0], best_total);
                    mismatch_count++;
                end
                void'(totals_due.pop_front());
            end
        end
        out_stall <= ($urandom_range(99) < sink_hold_pct);
    end

    // End the run if no word moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("grid_max_path_dp_core: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned      grids;
        int unsigned      cells;
        int unsigned      sel;
        int unsigned      phase_no;
        logic [CFG_W-1:0] nr;
        logic [CFG_W-1:0] nc;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        gold           <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_NUM_ROWS;
        cfg_data       <= '0;
        rand_cells     = 0;
        src_gap_pct    = 16;
        sink_hold_pct  = 45;
        cfg_rows       = SIZE_RESET;
        cfg_cols       = SIZE_RESET;
        above          = '0;
        last_max       = '0;
        row_pos        = 0;
        col_pos        = 0;
        foreach (col_tot[i])
        begin
            col_tot[i] = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Row count out of reset: one column, all rows
        drain();
        cfg_write(CFG_NUM_COLS, '0);
        feed_cells(eff_size(cfg_rows, MAX_ROWS) * eff_size(cfg_cols, MAX_COLS));

        // Directed table
        dir_rows.push_back(cfg_row(CFG_NUM_ROWS, 9'd1));
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd1));
        dir_rows.push_back(cell_row(16'hFFFF, 1'b1, 24'd65535));
        // zero sizes act as one
        dir_rows.push_back(cfg_row(CFG_NUM_ROWS, 9'd0));
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd0));
        dir_rows.push_back(cell_row(16'd1234, 1'b1, 24'd1234));
        // single row: left neighbor only
        dir_rows.push_back(cfg_row(CFG_NUM_ROWS, 9'd1));
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd3));
        dir_rows.push_back(cell_row(16'd5, 1'b0, '0));
        dir_rows.push_back(cell_row(16'hFFFF, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd7, 1'b1, 24'd65547));
        // single column: plain maximum
        dir_rows.push_back(cfg_row(CFG_NUM_ROWS, 9'd3));
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd1));
        dir_rows.push_back(cell_row(16'd3, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd9, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd4, 1'b1, 24'd9));
        // classic 3x3 mine, column by column
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd3));
        dir_rows.push_back(cell_row(16'd1, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd2, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd0, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd3, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd1, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd6, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd3, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd4, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd4, 1'b1, 24'd12));
        // unknown index keeps the grid going; a real write restarts it
        dir_rows.push_back(cfg_row(CFG_NUM_ROWS, 9'd2));
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd2));
        dir_rows.push_back(cell_row(16'hFFFF, 1'b0, '0));
        dir_rows.push_back(cell_row(16'hFFFF, 1'b0, '0));
        dir_rows.push_back(cfg_row(CFG_SPARE_2, 9'd5));
        dir_rows.push_back(cell_row(16'd1, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd2, 1'b1, 24'd65537));
        dir_rows.push_back(cell_row(16'd9, 1'b0, '0));
        dir_rows.push_back(cfg_row(CFG_SPARE_3, 9'h1FF));
        dir_rows.push_back(cfg_row(CFG_NUM_COLS, 9'd2));
        dir_rows.push_back(cell_row(16'd1, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd2, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd3, 1'b0, '0));
        dir_rows.push_back(cell_row(16'd4, 1'b1, 24'd6));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                feed_cell(dir_rows[i].g, dir_rows[i].typed, dir_rows[i].total);
            end
        end

        // Random phases: new sizes, a few whole grids, sometimes a cut-off grid
        phase_no = 0;
        while (rand_cells < RAND_CELLS)
        begin
            if (rand_cells < RAND_CELLS / 3)
            begin
                src_gap_pct   = 16;
                sink_hold_pct = 45;
            end
            else if (rand_cells < 2 * RAND_CELLS / 3)
            begin
                src_gap_pct   = 45;
                sink_hold_pct = 16;
            end
            else
            begin
                src_gap_pct   = 0;
                sink_hold_pct = 0;
            end
            drain();
            if (phase_no == 0)
            begin
                cfg_write(CFG_NUM_ROWS, 9'h1FF);
                cfg_write(CFG_NUM_COLS, 9'd1);
            end
            else if (phase_no == 1)
            begin
                cfg_write(CFG_NUM_ROWS, 9'd1);
                cfg_write(CFG_NUM_COLS, 9'd256);
            end
            else
            begin
                if ($urandom_range(99) < 10)
                begin
                    cfg_write($urandom_range(1) ? CFG_SPARE_3 : CFG_SPARE_2, CFG_W'($urandom));
                end
                nr  = cfg_rows;
                nc  = cfg_cols;
                sel = $urandom_range(99);
                if (sel < 15)
                begin
                    nr = pick_size();
                end
                else if (sel < 30)
                begin
                    nc = pick_size();
                end
                else
                begin
                    nr = pick_size();
                    nc = pick_size();
                end
                // keep one of the two dimensions small when the other is wide
                if (eff_size(nr, MAX_ROWS) * eff_size(nc, MAX_COLS) > 640)
                begin
                    nc = CFG_W'($urandom_range(0, 2));
                end
                if (sel < 15 || sel >= 30)
                begin
                    cfg_write(CFG_NUM_ROWS, nr);
                end
                if (sel >= 15 || nc != cfg_cols)
                begin
                    cfg_write(CFG_NUM_COLS, nc);
                end
            end
            cells = eff_size(cfg_rows, MAX_ROWS) * eff_size(cfg_cols, MAX_COLS);
            grids = (cells > 64) ? 1 : $urandom_range(1, 4);
            repeat (grids)
            begin
                feed_cells(cells);
                // sometimes pause until the result is out
                if ($urandom_range(99) < 20)
                begin
                    drain();
                end
            end
            if (cells > 1 && $urandom_range(99) < 15)
            begin
                feed_cells($urandom_range(1, cells - 1));
            end
            phase_no++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && totals_due.size() == 0)
        begin
            $display("grid_max_path_dp_core: match");
        end
        else
        begin
            $display("grid_max_path_dp_core: mismatch");
        end
        $finish;
    end

endmodule
